// ===== src/ghd_pkg.sv =====
// shared constants and types for the grid humidity diffusion step unit
`default_nettype none
package ghd_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int CELL_DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(CELL_DEPTH);
    localparam int COUNT_W     = $clog2(CELL_DEPTH + 1);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    localparam logic [15:0] SATURATED  = 16'hFFFF;
    localparam logic [14:0] COEF_LIMIT = 15'd16384;
    localparam logic [16:0] LIGHT_ONE  = 17'd65536;

    // command codes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_WRAP    = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_COPY = 6'b000100,
        S_DIFF = 6'b001000,
        S_EVAP = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

endpackage
`default_nettype wire

// ===== src/grid_humidity_diffusion_step_unit.sv =====
// grid humidity store with an iterative five-point diffusion and evaporation step
//
//  channel | signals                         | direction | transfer
//  in      | in_valid, in_stall, 7 fields    | in        | valid & !stall
//  out     | out_valid, out_stall, 2 fields  | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, idx, data | in        | valid & ready
//
// load: result word ready the cycle after acceptance; read: the word is read
// from the store, then registered in S_READ. step: snapshot copy, per-cell diffusion
// (one snapshot port, one shared multiplier), then per-cell evaporation.
// the input stalls while a command runs or while the result word is held.
// reset clears control, sets config to 64 x 64 unwrapped; grid stores not cleared.
`default_nettype none
module grid_humidity_diffusion_step_unit
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire  [1:0]             mode,
    input  wire  [11:0]            cell_index,
    input  wire  [15:0]            humidity_value,
    input  wire                    wet_flag,
    input  wire  [16:0]            light_fraction,
    input  wire  [14:0]            diffusion_coefficient,
    input  wire  [15:0]            evaporation_weight,
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [15:0]            read_humidity,
    output logic                   step_done,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [1:0]             cfg_index,
    input  wire  [6:0]             cfg_data
);
    import ghd_pkg::*;

    // memories
    logic [15:0] hum_mem   [CELL_DEPTH];
    logic        wet_mem   [CELL_DEPTH];
    logic [16:0] light_mem [CELL_DEPTH];
    logic [15:0] snap_mem  [CELL_DEPTH];

    logic [15:0] hum_rd_reg;
    logic        wet_rd_reg;
    logic [16:0] light_rd_reg;
    logic [15:0] snap_rd_reg;

    // control and configuration
    state_t             state_reg;
    logic [6:0]         cols_cfg_reg;
    logic [6:0]         rows_cfg_reg;
    logic               wrap_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [2:0]         ph_reg;
    logic [14:0]        coef_reg;
    logic [15:0]        weight_reg;
    logic               out_valid_reg;
    logic [15:0]        read_humidity_reg;
    logic               step_done_reg;

    // per-cell working registers
    logic [15:0]        self_reg;
    logic               self_wet_reg;
    logic               nb_ok_reg;
    logic signed [19:0] sum_reg;
    logic [48:0]        mul_reg;
    logic [15:0]        val_reg;
    logic               cell_wet_reg;
    logic [16:0]        light_reg;

    logic               accept;
    logic [6:0]         cols_eff;
    logic [6:0]         rows_eff;
    logic [13:0]        total_full;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_humidity = read_humidity_reg;
    assign step_done = step_done_reg;

    // grid size with out-of-range counts pulled into range
    always_comb
    begin
        cols_eff = (cols_cfg_reg == 7'd0) ? 7'd1 :
                   (cols_cfg_reg > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cols_cfg_reg;
        rows_eff = (rows_cfg_reg == 7'd0) ? 7'd1 :
                   (rows_cfg_reg > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_cfg_reg;
        total_full = 14'(cols_eff) * 14'(rows_eff);
    end

    // neighbor address for the diffusion phase, order right, left, down, up
    logic [1:0]        nb_sel;
    logic [12:0]       nb_addr_w;
    logic              nb_ok;
    logic [ADDR_W-1:0] snap_ra;
    logic [12:0]       idx_w;
    logic [12:0]       cols_w;

    always_comb
    begin
        nb_sel    = 2'(ph_reg - 3'd1);
        idx_w     = 13'(idx_reg);
        cols_w    = 13'(cols_eff);
        nb_ok     = 1'b1;
        nb_addr_w = idx_w;
        case (nb_sel)
            2'd0:
            begin
                if (7'(col_reg) + 7'd1 >= cols_eff)
                begin
                    nb_ok     = wrap_reg;
                    nb_addr_w = idx_w + 13'd1 - cols_w;
                end
                else
                begin
                    nb_addr_w = idx_w + 13'd1;
                end
            end
            2'd1:
            begin
                if (col_reg == '0)
                begin
                    nb_ok     = wrap_reg;
                    nb_addr_w = idx_w + cols_w - 13'd1;
                end
                else
                begin
                    nb_addr_w = idx_w - 13'd1;
                end
            end
            2'd2:
            begin
                if (7'(row_reg) + 7'd1 >= rows_eff)
                begin
                    nb_ok     = wrap_reg;
                    nb_addr_w = 13'(col_reg);
                end
                else
                begin
                    nb_addr_w = idx_w + cols_w;
                end
            end
            default:
            begin
                if (row_reg == '0)
                begin
                    nb_ok     = wrap_reg;
                    nb_addr_w = idx_w + 13'(total_reg) - cols_w;
                end
                else
                begin
                    nb_addr_w = idx_w - cols_w;
                end
            end
        endcase
        snap_ra = (ph_reg == 3'd0) ? idx_reg : nb_addr_w[ADDR_W-1:0];
    end

    // neighbor difference with wet neighbors taken as saturated
    logic signed [19:0] nb_diff;
    logic [15:0]        nb_val;
    always_comb
    begin
        nb_val  = wet_rd_reg ? SATURATED : snap_rd_reg;
        nb_diff = signed'(20'(nb_val)) - signed'(20'(self_reg));
    end

    // shared multiplier operand selection
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [18:0] sum_mag;
    always_comb
    begin
        sum_mag = sum_reg[19] ? 19'(-sum_reg) : 19'(sum_reg);
        mul_a   = 32'(sum_mag);
        mul_b   = 17'(coef_reg);
        if (state_reg == S_EVAP)
        begin
            if (ph_reg == 3'd1)
            begin
                mul_a = 32'(weight_reg);
                mul_b = 17'(hum_rd_reg);
            end
            else
            begin
                mul_a = mul_reg[31:0];
                mul_b = light_reg;
            end
        end
    end

    // diffusion result: round halves away from zero, then clamp
    logic [35:0]        rnd_sum;
    logic [17:0]        rnd_mag;
    logic signed [19:0] diff_val;
    logic [15:0]        diff_out;
    always_comb
    begin
        rnd_sum  = 36'(mul_reg[34:0]) + 36'd32768;
        rnd_mag  = rnd_sum[33:16];
        diff_val = sum_reg[19] ? signed'(20'(self_reg)) - signed'(20'(rnd_mag))
                               : signed'(20'(self_reg)) + signed'(20'(rnd_mag));
        if (self_wet_reg)
            diff_out = SATURATED;
        else if (diff_val < 0)
            diff_out = 16'd0;
        else if (diff_val > signed'(20'(SATURATED)))
            diff_out = SATURATED;
        else
            diff_out = diff_val[15:0];
    end

    // evaporation result
    logic [49:0] loss_sum;
    logic [17:0] loss;
    logic [15:0] evap_out;
    always_comb
    begin
        loss_sum = 50'(mul_reg) + 50'h0_8000_0000;
        loss     = loss_sum[49:32];
        if (cell_wet_reg)
            evap_out = SATURATED;
        else if (loss >= 18'(val_reg))
            evap_out = 16'd0;
        else
            evap_out = 16'(18'(val_reg) - loss);
    end

    // memory ports
    logic              hum_we;
    logic [ADDR_W-1:0] hum_wa;
    logic [15:0]       hum_wd;
    logic [ADDR_W-1:0] hum_ra;
    logic [ADDR_W-1:0] wet_ra;
    logic              load_we;
    logic              snap_we;
    logic [ADDR_W-1:0] snap_wa;
    logic [16:0]       light_sat;

    always_comb
    begin
        load_we   = accept && (mode == MODE_LOAD);
        light_sat = (light_fraction > LIGHT_ONE) ? LIGHT_ONE : light_fraction;
        hum_we    = load_we;
        hum_wa    = cell_index;
        hum_wd    = humidity_value;
        if (state_reg == S_DIFF && ph_reg == 3'd7)
        begin
            hum_we = 1'b1;
            hum_wa = idx_reg;
            hum_wd = diff_out;
        end
        else if (state_reg == S_EVAP && ph_reg == 3'd3)
        begin
            hum_we = 1'b1;
            hum_wa = idx_reg;
            hum_wd = evap_out;
        end
        hum_ra  = (state_reg == S_IDLE) ? cell_index :
                  (state_reg == S_EVAP) ? idx_reg : cnt_reg[ADDR_W-1:0];
        wet_ra  = (state_reg == S_EVAP) ? idx_reg : snap_ra;
        snap_we = (state_reg == S_COPY) && (cnt_reg != '0);
        snap_wa = ADDR_W'(cnt_reg - COUNT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (hum_we)
            hum_mem[hum_wa] <= hum_wd;
        hum_rd_reg <= hum_mem[hum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            wet_mem[cell_index]   <= wet_flag;
            light_mem[cell_index] <= light_sat;
        end
        wet_rd_reg   <= wet_mem[wet_ra];
        light_rd_reg <= light_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (snap_we)
            snap_mem[snap_wa] <= hum_rd_reg;
        snap_rd_reg <= snap_mem[snap_ra];
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIFF)
        begin
            if (ph_reg == 3'd1)
            begin
                self_reg     <= snap_rd_reg;
                self_wet_reg <= wet_rd_reg;
                sum_reg      <= '0;
            end
            else if (ph_reg >= 3'd2 && ph_reg <= 3'd5 && nb_ok_reg)
            begin
                sum_reg <= sum_reg + nb_diff;
            end
            if (ph_reg >= 3'd1 && ph_reg <= 3'd4)
                nb_ok_reg <= nb_ok;
        end
        if (state_reg == S_EVAP && ph_reg == 3'd1)
        begin
            val_reg      <= hum_rd_reg;
            cell_wet_reg <= wet_rd_reg;
            light_reg    <= light_rd_reg;
        end
        mul_reg <= 49'(mul_a) * 49'(mul_b);
        if (accept)
        begin
            coef_reg   <= (diffusion_coefficient > COEF_LIMIT) ? COEF_LIMIT
                                                               : diffusion_coefficient;
            weight_reg <= evaporation_weight;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 7'd64;
            rows_cfg_reg <= 7'd64;
            wrap_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLUMNS: cols_cfg_reg <= cfg_data;
                REG_ROWS:    rows_cfg_reg <= cfg_data;
                REG_WRAP:    wrap_reg     <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // sequencer and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            total_reg         <= '0;
            cnt_reg           <= '0;
            idx_reg           <= '0;
            col_reg           <= '0;
            row_reg           <= '0;
            ph_reg            <= '0;
            out_valid_reg     <= 1'b0;
            read_humidity_reg <= '0;
            step_done_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                        case (mode)
                            MODE_READ: state_reg <= S_READ;
                            MODE_STEP:
                            begin
                                total_reg <= COUNT_W'(total_full);
                                state_reg <= S_COPY;
                            end
                            default:
                            begin
                                out_valid_reg     <= 1'b1;
                                read_humidity_reg <= '0;
                                step_done_reg     <= 1'b0;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    out_valid_reg     <= 1'b1;
                    read_humidity_reg <= hum_rd_reg;
                    step_done_reg     <= 1'b0;
                    state_reg         <= S_IDLE;
                end
                S_COPY:
                begin
                    // read stream one ahead of the snapshot write
                    if (cnt_reg == total_reg)
                    begin
                        state_reg <= S_DIFF;
                        idx_reg   <= '0;
                        col_reg   <= '0;
                        row_reg   <= '0;
                        ph_reg    <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + COUNT_W'(1);
                    end
                end
                S_DIFF:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd7)
                    begin
                        if (COUNT_W'(idx_reg) + COUNT_W'(1) == total_reg)
                        begin
                            state_reg <= S_EVAP;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + ADDR_W'(1);
                            if (7'(col_reg) + 7'd1 == cols_eff)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + ROW_W'(1);
                            end
                            else
                            begin
                                col_reg <= col_reg + COL_W'(1);
                            end
                        end
                    end
                end
                S_EVAP:
                begin
                    if (ph_reg == 3'd3)
                    begin
                        ph_reg <= '0;
                        if (COUNT_W'(idx_reg) + COUNT_W'(1) == total_reg)
                            state_reg <= S_DONE;
                        else
                            idx_reg <= idx_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg     <= 1'b1;
                    read_humidity_reg <= '0;
                    step_done_reg     <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while a command runs");

    a_done_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && step_done_reg) |-> (read_humidity_reg == 16'd0))
        else $error("step result carries read data");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> (cnt_reg <= total_reg))
        else $error("copy counter past grid size");

    a_evap_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAP) |-> (ph_reg <= 3'd3))
        else $error("evaporation phase out of range");

endmodule
`default_nettype wire
